// ----- rtl/core/jcur_pkg.sv -----
// Shared widths, reset values, register indexes and the step table for the
// joystick cursor block. No dependencies.
`default_nettype none

package jcur_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int MAP_SIZE_DEF    = 2048;

    // Field widths
    localparam int CENTER_W  = 10;
    localparam int DZ_W      = 9;
    localparam int HALF_W    = 5;
    localparam int POS_W     = 9;
    localparam int MAP_OFF_W = 11;
    localparam int SCR_W     = 10;
    localparam int MAP_W     = 12;
    localparam int STEP_M_W  = 10;
    localparam int STEP_W    = 4;
    localparam int STEP_N_W  = 3;
    localparam int SUM_W     = 11;

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_OFF_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_OFF_Y  = 3'd6;

    // Reset values
    localparam logic [CENTER_W-1:0] CENTER_RST  = 10'd512;
    localparam logic [DZ_W-1:0]     DZ_RST      = 9'd64;
    localparam logic [HALF_W-1:0]   HALF_RST    = 5'd4;
    localparam logic [POS_W-1:0]    LIMIT_X_RST = 9'd415;
    localparam logic [POS_W-1:0]    LIMIT_Y_RST = 9'd315;
    localparam logic [POS_W-1:0]    CUR_X_RST   = 9'd210;
    localparam logic [POS_W-1:0]    CUR_Y_RST   = 9'd160;

    // Saturation point of the magnitude above the deadzone
    localparam logic [STEP_M_W-1:0] M_MAX = 10'd1023;

    // Inclusive m windows where 8*sin(1.2*m/512) >= k, k = 1..7
    localparam int NUM_WIN = 7;
    localparam logic [10:0] WIN_LO [NUM_WIN] = '{
        11'd54, 11'd108, 11'd165, 11'd224, 11'd289, 11'd362, 11'd455
    };
    localparam logic [10:0] WIN_HI [NUM_WIN] = '{
        11'd1286, 11'd1232, 11'd1176, 11'd1117, 11'd1052, 11'd978, 11'd885
    };

    typedef struct packed {
        logic [CENTER_W-1:0]  center;
        logic [DZ_W-1:0]      deadzone;
        logic [HALF_W-1:0]    half;
        logic [POS_W-1:0]     limit_x;
        logic [POS_W-1:0]     limit_y;
        logic [MAP_OFF_W-1:0] map_off_x;
        logic [MAP_OFF_W-1:0] map_off_y;
    } t_cfg;

    // floor(8*sin(1.2*m/512)): count of windows holding m
    function automatic logic [STEP_N_W-1:0] floor_step(input logic [STEP_M_W-1:0] m);
        logic [STEP_N_W-1:0] n;
        logic [10:0]         mx;
        n  = '0;
        mx = {1'b0, m};
        for (int k = 0; k < NUM_WIN; k++) begin
            if (mx >= WIN_LO[k] && mx <= WIN_HI[k]) begin
                n = n + 3'd1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/jcur_cfg.sv -----
// Configuration register file for the joystick cursor.
// Depends on jcur_pkg.
`default_nettype none

module jcur_cfg #(
    parameter int MAP_SIZE = jcur_pkg::MAP_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [jcur_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [jcur_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output jcur_pkg::t_cfg                 o_cfg
);
    import jcur_pkg::*;

    // map column/row at screen zero that puts the start cursor mid-map
    localparam logic [MAP_OFF_W-1:0] MAP_OFF_X_RST =
        MAP_OFF_W'(MAP_SIZE / 2 - int'(CUR_X_RST));
    localparam logic [MAP_OFF_W-1:0] MAP_OFF_Y_RST =
        MAP_OFF_W'(MAP_SIZE / 2 - int'(CUR_Y_RST));

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center    <= CENTER_RST;
            r_cfg.deadzone  <= DZ_RST;
            r_cfg.half      <= HALF_RST;
            r_cfg.limit_x   <= LIMIT_X_RST;
            r_cfg.limit_y   <= LIMIT_Y_RST;
            r_cfg.map_off_x <= MAP_OFF_X_RST;
            r_cfg.map_off_y <= MAP_OFF_Y_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_CENTER:    r_cfg.center    <= i_cfg_wdata[CENTER_W-1:0];
                REG_DEADZONE:  r_cfg.deadzone  <= i_cfg_wdata[DZ_W-1:0];
                REG_HALF:      r_cfg.half      <= i_cfg_wdata[HALF_W-1:0];
                REG_LIMIT_X:   r_cfg.limit_x   <= i_cfg_wdata[POS_W-1:0];
                REG_LIMIT_Y:   r_cfg.limit_y   <= i_cfg_wdata[POS_W-1:0];
                REG_MAP_OFF_X: r_cfg.map_off_x <= i_cfg_wdata[MAP_OFF_W-1:0];
                REG_MAP_OFF_Y: r_cfg.map_off_y <= i_cfg_wdata[MAP_OFF_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/core/jcur_axis.sv -----
// One cursor axis: deadzone test, step lookup, clamp and old-patch corner.
// Depends on jcur_pkg (widths, floor_step).
`default_nettype none

module jcur_axis #(
    parameter int SAMPLE_BITS = jcur_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [((SAMPLE_BITS > jcur_pkg::CENTER_W) ? SAMPLE_BITS
                          : jcur_pkg::CENTER_W):0] i_offset,
    input  logic [jcur_pkg::DZ_W-1:0]      i_deadzone,
    input  logic [jcur_pkg::HALF_W-1:0]    i_half,
    input  logic [jcur_pkg::POS_W-1:0]     i_limit,
    input  logic [jcur_pkg::MAP_OFF_W-1:0] i_map_off,
    input  logic [jcur_pkg::POS_W-1:0]     i_cur,
    output logic                           o_hit,
    output logic [jcur_pkg::POS_W-1:0]     o_next,
    output logic [jcur_pkg::SCR_W-1:0]     o_erase_scr,
    output logic [jcur_pkg::MAP_W-1:0]     o_erase_map
);
    import jcur_pkg::*;

    localparam int MAG_W = (SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W;

    logic [MAG_W-1:0]           w_mag;
    logic [MAG_W-1:0]           w_m_full;
    logic [STEP_M_W-1:0]        w_m;
    logic [STEP_N_W-1:0]        w_n;
    logic signed [STEP_W-1:0]   w_step;
    logic signed [SUM_W-1:0]    w_sum;

    assign w_mag    = i_offset[MAG_W] ? MAG_W'(-i_offset) : i_offset[MAG_W-1:0];
    assign o_hit    = w_mag > MAG_W'(i_deadzone);
    assign w_m_full = w_mag - MAG_W'(i_deadzone);
    assign w_m      = (w_m_full > MAG_W'(M_MAX)) ? M_MAX : w_m_full[STEP_M_W-1:0];
    assign w_n      = floor_step(w_m);

    // negative side rounds away from zero: -(n+1) == ~n
    always_comb begin
        if (!o_hit) begin
            w_step = '0;
        end else if (i_offset[MAG_W]) begin
            w_step = ~{1'b0, w_n};
        end else begin
            w_step = {1'b0, w_n};
        end
    end

    assign w_sum = $signed({2'b00, i_cur})
                 + $signed({{(SUM_W-STEP_W){w_step[STEP_W-1]}}, w_step});

    // low bound has priority: a sum below half clamps to half, even when limit is below half
    always_comb begin
        if (w_sum < $signed({{(SUM_W-HALF_W){1'b0}}, i_half})) begin
            o_next = POS_W'(i_half);
        end else if (w_sum > $signed({{(SUM_W-POS_W){1'b0}}, i_limit})) begin
            o_next = i_limit;
        end else begin
            o_next = w_sum[POS_W-1:0];
        end
    end

    assign o_erase_scr = SCR_W'(i_cur) - SCR_W'(i_half);
    assign o_erase_map = MAP_W'(i_map_off) + MAP_W'(i_cur) - MAP_W'(i_half);

endmodule

`default_nettype wire

// ----- rtl/core/joystick_cursor_with_deadzone.sv -----
// Joystick cursor: a request passes the input register, then the result
// register; throughput one request per cycle while m_axis_tready is high.
// Input register, one pass of step/clamp logic, result register.
// Reset (i_rst_n low, synchronous) empties both stages, restores the config
// registers to their defaults and homes the cursor to (210, 160).
// Depends on jcur_pkg, jcur_cfg, jcur_axis.
`default_nettype none

module joystick_cursor_with_deadzone #(
    parameter int SAMPLE_BITS = jcur_pkg::SAMPLE_BITS_DEF,
    parameter int MAP_SIZE    = jcur_pkg::MAP_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // config write port
    input  logic                            i_cfg_wr_en,
    input  logic [jcur_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [jcur_pkg::CFG_DATA_W-1:0] i_cfg_wdata,

    // sample request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata, low bit up: horiz_sample, vert_sample, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,

    // cursor result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata, low bit up: moved, pos_x, pos_y, erase_screen_x, erase_screen_y,
    // erase_map_x, erase_map_y, zero pad
    output logic [63:0]                     m_axis_tdata
);
    import jcur_pkg::*;

    localparam int MAG_W = (SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W;
    localparam int OFF_W = MAG_W + 1;

    t_cfg w_cfg;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    jcur_cfg #(
        .MAP_SIZE (MAP_SIZE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_h;
    logic [SAMPLE_BITS-1:0] r_in_v;
    logic                   w_advance;
    logic                   w_in_fire;

    logic                   r_out_valid;

    // stage 1 moves into the result register when that one is free or draining
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_h <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_in_v <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    // ---------------------------------------------------------------
    // Centering; horizontal axis is mounted inverted
    // ---------------------------------------------------------------
    logic signed [OFF_W-1:0] w_off_x;
    logic signed [OFF_W-1:0] w_off_y;

    assign w_off_x = $signed(OFF_W'(w_cfg.center)) - $signed(OFF_W'(r_in_h));
    assign w_off_y = $signed(OFF_W'(r_in_v)) - $signed(OFF_W'(w_cfg.center));

    // ---------------------------------------------------------------
    // Cursor state and per-axis step logic
    // ---------------------------------------------------------------
    logic [POS_W-1:0] r_cur_x;
    logic [POS_W-1:0] r_cur_y;

    logic             w_hit_x,   w_hit_y;
    logic [POS_W-1:0] w_next_x,  w_next_y;
    logic [SCR_W-1:0] w_scr_x,   w_scr_y;
    logic [MAP_W-1:0] w_map_x,   w_map_y;
    logic             w_moved;

    jcur_axis #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_axis_x (
        .i_offset    (w_off_x),
        .i_deadzone  (w_cfg.deadzone),
        .i_half      (w_cfg.half),
        .i_limit     (w_cfg.limit_x),
        .i_map_off   (w_cfg.map_off_x),
        .i_cur       (r_cur_x),
        .o_hit       (w_hit_x),
        .o_next      (w_next_x),
        .o_erase_scr (w_scr_x),
        .o_erase_map (w_map_x)
    );

    jcur_axis #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_axis_y (
        .i_offset    (w_off_y),
        .i_deadzone  (w_cfg.deadzone),
        .i_half      (w_cfg.half),
        .i_limit     (w_cfg.limit_y),
        .i_map_off   (w_cfg.map_off_y),
        .i_cur       (r_cur_y),
        .o_hit       (w_hit_y),
        .o_next      (w_next_y),
        .o_erase_scr (w_scr_y),
        .o_erase_map (w_map_y)
    );

    // either axis past the deadzone moves (and clamps) both axes;
    // otherwise the cursor is left alone even if it sits outside the limits
    assign w_moved = w_hit_x || w_hit_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= CUR_X_RST;
            r_cur_y <= CUR_Y_RST;
        end else if (w_advance && w_moved) begin
            r_cur_x <= w_next_x;
            r_cur_y <= w_next_y;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: result register
    // ---------------------------------------------------------------
    logic             r_moved;
    logic [POS_W-1:0] r_pos_x;
    logic [POS_W-1:0] r_pos_y;
    logic [SCR_W-1:0] r_scr_x;
    logic [SCR_W-1:0] r_scr_y;
    logic [MAP_W-1:0] r_map_x;
    logic [MAP_W-1:0] r_map_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // erase corner fields read zero on a tick without movement
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_moved <= w_moved;
            r_pos_x <= w_moved ? w_next_x : r_cur_x;
            r_pos_y <= w_moved ? w_next_y : r_cur_y;
            r_scr_x <= w_moved ? w_scr_x : '0;
            r_scr_y <= w_moved ? w_scr_y : '0;
            r_map_x <= w_moved ? w_map_x : '0;
            r_map_y <= w_moved ? w_map_y : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_map_y, r_map_x, r_scr_y, r_scr_x,
                            r_pos_y, r_pos_x, r_moved};

endmodule

`default_nettype wire
